FILE: design/mf3s_pkg.sv
// Shared types and constants of the 3x3 shrinking-border median filter.
// No dependencies.
package mf3s_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 13;
    localparam int IDX_W      = 1;
    localparam int HGT_W      = 13;
    localparam int ROW_W      = 13;
    localparam int TAPS       = 9;
    localparam int WIN        = 3;
    localparam int WIDTH_W    = 11;
    localparam int MAX_HEIGHT = 4096;
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic req_type;
        pix_t pixel_in;
    } in_item_t;

    typedef struct packed {
        pix_t pixel_out;
        logic frame_last;
    } out_item_t;

    typedef struct packed {
        logic            emit;
        logic            last;
        logic [TAPS-1:0] mask;
    } tap_ctl_t;

endpackage

FILE: design/mf3s_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mf3s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mf3s_ctrl.sv
// Frame size registers, raster position counters and tap clipping mask.
// Depends on mf3s_pkg.
module mf3s_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           en,
    input  logic                                           in_valid,
    input  mf3s_pkg::in_item_t                             in_item,
    input  logic                                           cfg_write,
    input  logic [mf3s_pkg::IDX_W-1:0]                     cfg_addr,
    input  logic [mf3s_pkg::CFG_W-1:0]                     cfg_data,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_col,
    output logic                                           a_valid,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] a_col,
    output mf3s_pkg::pix_t                                 a_px,
    output mf3s_pkg::tap_ctl_t                             a_ctl
);

    import mf3s_pkg::*;

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int RST_W  = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;

    logic [CW-1:0]    w_reg;
    logic [HGT_W-1:0] h_reg;
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             a_valid_reg;
    logic [AW-1:0]    a_col_reg;
    pix_t             a_px_reg;
    tap_ctl_t         a_ctl_reg;

    logic [WIDTH_W-1:0] wr_w;
    logic [HGT_W-1:0]   wr_h;
    logic [CW:0]        w_ext, in_col_inc, out_col_inc;
    logic [ROW_W:0]     h_ext, out_row_inc;
    logic               emit, last, in_row_end, out_row_end;
    logic [WIN-1:0]     rv, cv;
    tap_ctl_t           ctl;

    assign wr_w = cfg_data[WIDTH_W-1:0];
    assign wr_h = cfg_data[HGT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= CW'(RST_W);
            h_reg <= HGT_W'(RST_HEIGHT);
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:
                begin
                    if (wr_w == '0)
                        w_reg <= CW'(1);
                    else if (32'(wr_w) > MAX_WIDTH)
                        w_reg <= CW'(MAX_WIDTH);
                    else
                        w_reg <= CW'(wr_w);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (wr_h == '0)
                        h_reg <= HGT_W'(1);
                    else if (32'(wr_h) > MAX_HEIGHT)
                        h_reg <= HGT_W'(MAX_HEIGHT);
                    else
                        h_reg <= wr_h;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        w_ext       = {1'b0, w_reg};
        h_ext       = (ROW_W + 1)'(h_reg);
        in_col_inc  = {1'b0, in_col_reg} + (CW + 1)'(1);
        out_col_inc = {1'b0, out_col_reg} + (CW + 1)'(1);
        out_row_inc = {1'b0, out_row_reg} + (ROW_W + 1)'(1);
        in_row_end  = in_col_inc >= w_ext;
        out_row_end = out_col_inc >= w_ext;

        emit = (in_row_reg >= ROW_W'(2)) ||
               ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        last = emit && (out_row_inc >= h_ext) && out_row_end;

        rv[0] = (out_row_reg != '0) && ({1'b0, out_row_reg} <= h_ext);
        rv[1] = {1'b0, out_row_reg} < h_ext;
        rv[2] = out_row_inc < h_ext;
        cv[0] = (out_col_reg != '0) && ({1'b0, out_col_reg} <= w_ext);
        cv[1] = {1'b0, out_col_reg} < w_ext;
        cv[2] = out_col_inc < w_ext;

        ctl.emit = emit;
        ctl.last = last;
        for (int dr = 0; dr < WIN; dr++)
        begin
            for (int dc = 0; dc < WIN; dc++)
            begin
                ctl.mask[dr * WIN + dc] = rv[dr] & cv[dc];
            end
        end

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (emit)
        begin
            if (out_row_end)
            begin
                out_col_next = '0;
                if (out_row_reg != '1)
                    out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_inc[CW-1:0];
            end
        end

        in_col_next = in_col_inc[CW-1:0];
        in_row_next = in_row_reg;
        if (in_row_end)
        begin
            in_col_next = '0;
            if (in_row_reg != '1)
                in_row_next = in_row_reg + ROW_W'(1);
        end

        // frame end: everything restarts at the origin
        if (last)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            if (in_valid)
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            a_col_reg <= in_col_reg[AW-1:0];
            a_px_reg  <= in_item.req_type ? '0 : in_item.pixel_in;
            a_ctl_reg <= ctl;
        end
    end

    assign rd_col  = in_col_reg[AW-1:0];
    assign a_valid = a_valid_reg;
    assign a_col   = a_col_reg;
    assign a_px    = a_px_reg;
    assign a_ctl   = a_ctl_reg;

endmodule

FILE: design/mf3s_median.sv
// Two-stage masked median of the 3x3 window: pairwise order, then rank select.
// Depends on mf3s_pkg.
module mf3s_median (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  b_valid,
    input  mf3s_pkg::tap_ctl_t                    b_ctl,
    input  mf3s_pkg::pix_t [mf3s_pkg::TAPS-1:0]   window,
    output logic                                  out_valid,
    output mf3s_pkg::out_item_t                   out_item
);

    import mf3s_pkg::*;

    logic                       c_valid_reg;
    logic                       c_last_reg;
    logic [TAPS-1:0]            c_mask_reg;
    pix_t [TAPS-1:0]            c_vals_reg;
    logic [TAPS-1:0][TAPS-1:0]  c_prec_reg;
    logic [TAPS-1:0][TAPS-1:0]  prec;
    logic                       out_valid_reg;
    out_item_t                  out_item_reg;
    pix_t                       sel;

    // prec[i][j]: tap j sorts ahead of tap i (ties broken by index)
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                if (j == i)
                    prec[i][j] = 1'b0;
                else
                    prec[i][j] = (window[j] < window[i]) ||
                                 ((window[j] == window[i]) && (j < i));
            end
        end
    end

    always_comb
    begin
        logic [3:0] n;
        logic [3:0] rank;
        n    = '0;
        rank = '0;
        sel  = '0;
        for (int j = 0; j < TAPS; j++)
        begin
            n = n + 4'(c_mask_reg[j]);
        end
        for (int i = 0; i < TAPS; i++)
        begin
            rank = '0;
            for (int j = 0; j < TAPS; j++)
            begin
                rank = rank + 4'(c_mask_reg[j] & c_prec_reg[i][j]);
            end
            if (c_mask_reg[i] && (rank == (n >> 1)))
                sel = c_vals_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg   <= b_valid && b_ctl.emit;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_last_reg   <= b_ctl.last;
            c_mask_reg   <= b_ctl.mask;
            c_vals_reg   <= window;
            c_prec_reg   <= prec;
            out_item_reg <= '{pixel_out: sel, frame_last: c_last_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: design/median_filter_3x3_shrinking_border.sv
// Top level of the 3x3 shrinking-border median filter.
// Depends on mf3s_pkg, mf3s_ram, mf3s_ctrl, mf3s_median.
//
// Usage:
//   in_valid/in_ready/in_item carry one pixel (or flush tick) per item, in
//   raster order. out_valid/out_ready/out_item give one median per pixel, in
//   raster order, frame_last marking the frame's final pixel. After a frame
//   the source sends image_width+1 flush items to drain the last row.
//   cfg_write/cfg_addr/cfg_data set image_width (0) and image_height (1);
//   write them only while the block is idle.
// Throughput: one item per cycle while the output is not stalled. The
//   line stores are RAMs with registered read data; a read for an item is
//   issued on acceptance and the item is written back from the a stage,
//   with forwarding when consecutive items hit the same column.
// Pipeline: the item completing a window passes stages a, b, c and the
//   output register, where out_valid rises (image_width+1 items after its own pixel).
// Reset: counters, window and pipeline valids clear; size returns to
//   640x480 (width capped at MAX_WIDTH). Line stores need no clearing
//   pass: unwritten entries only feed clipped taps.
// Stall: with out_valid high and out_ready low the whole pipeline holds
//   and in_ready drops in the same cycle.
module median_filter_3x3_shrinking_border #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mf3s_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mf3s_pkg::out_item_t           out_item,
    input  logic                          cfg_write,
    input  logic [mf3s_pkg::IDX_W-1:0]    cfg_addr,
    input  logic [mf3s_pkg::CFG_W-1:0]    cfg_data
);

    import mf3s_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic            en;
    logic            accept;
    logic [AW-1:0]   rd_col;
    logic            a_valid;
    logic [AW-1:0]   a_col;
    pix_t            a_px;
    tap_ctl_t        a_ctl;
    pix_t            top_rdata, mid_rdata;
    pix_t            top_eff, mid_eff;
    logic            fwd_reg;
    pix_t            fwd_top_reg, fwd_mid_reg;
    pix_t [TAPS-1:0] window_reg;
    logic            b_valid_reg;
    tap_ctl_t        b_ctl_reg;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;

    mf3s_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .rd_col    (rd_col),
        .a_valid   (a_valid),
        .a_col     (a_col),
        .a_px      (a_px),
        .a_ctl     (a_ctl)
    );

    mf3s_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (en && a_valid),
        .waddr (a_col),
        .wdata (mid_eff),
        .re    (accept),
        .raddr (rd_col),
        .rdata (top_rdata)
    );

    mf3s_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (en && a_valid),
        .waddr (a_col),
        .wdata (a_px),
        .re    (accept),
        .raddr (rd_col),
        .rdata (mid_rdata)
    );

    // same column read while the previous item writes it (width of one, or the first item after a frame end)
    assign top_eff = fwd_reg ? fwd_top_reg : top_rdata;
    assign mid_eff = fwd_reg ? fwd_mid_reg : mid_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
            window_reg  <= '0;
        end
        else if (en)
        begin
            if (in_valid)
                fwd_reg <= a_valid && (a_col == rd_col);
            b_valid_reg <= a_valid;
            if (a_valid)
            begin
                for (int r = 0; r < WIN; r++)
                begin
                    window_reg[r * WIN]     <= window_reg[r * WIN + 1];
                    window_reg[r * WIN + 1] <= window_reg[r * WIN + 2];
                end
                window_reg[WIN - 1]       <= top_eff;
                window_reg[2 * WIN - 1]   <= mid_eff;
                window_reg[3 * WIN - 1]   <= a_px;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_top_reg <= mid_eff;
            fwd_mid_reg <= a_px;
        end
        if (en)
            b_ctl_reg <= a_ctl;
    end

    mf3s_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .b_valid   (b_valid_reg),
        .b_ctl     (b_ctl_reg),
        .window    (window_reg),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

FILE: design/mf3s_checker.sv
// Port-level checks for the median filter, bound to the top level.
// Depends on mf3s_pkg and median_filter_3x3_shrinking_border.
module mf3s_port_checks (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input mf3s_pkg::out_item_t        out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item changed or dropped while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared without pipeline advance");

endmodule

bind median_filter_3x3_shrinking_border mf3s_port_checks u_mf3s_port_checks (.*);
